@@ src/rgb_gray_histogram_stats_defines.svh @@
// Assertion macros shared by the histogram RTL files.
`ifndef RGB_GRAY_HISTOGRAM_STATS_DEFINES_SVH
`define RGB_GRAY_HISTOGRAM_STATS_DEFINES_SVH
`ifndef SYNTH
// Checked while reset is low.
`define RGHS_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rghs assertion failed");
// Checked on every edge, reset included.
`define RGHS_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("rghs assertion failed");
`else
`define RGHS_ASSERT(name, prop)
`define RGHS_ASSERT_ALWAYS(name, prop)
`endif
`endif

@@ src/rghs_pkg.sv @@
// Types, constants and helpers for the RGB/gray histogram block.
package rghs_pkg;

   localparam int COUNT_BITS = 24;
   localparam int BINS       = 256;
   localparam int BIN_AW     = $clog2(BINS);
   localparam int SUM_BITS   = 32;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [COUNT_BITS-1:0] COUNT_FULL = {COUNT_BITS{1'b1}};

   localparam logic [8:0] IDX_MAX   = 9'd256;
   localparam logic [8:0] IDX_SUM   = 9'd257;
   localparam logic [8:0] IDX_LIGHT = 9'd258;
   localparam logic [7:0] MID_LEVEL = 8'd127;

   localparam logic KIND_COUNT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [1:0] CH_GRAY = 2'd0;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // One queued transaction, gray level already worked out.
   typedef struct packed {
      logic       kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] gray;
      logic [1:0] channel;
      logic [8:0] index;
   } item_type;

   // Queue handshake between front and back.
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                  input logic [7:0] a);
      logic [SUM_BITS:0] t;
      t = {1'b0, s} + (SUM_BITS + 1)'(a);
      return t[SUM_BITS] ? {SUM_BITS{1'b1}} : t[SUM_BITS-1:0];
   endfunction

endpackage

@@ src/rgb_gray_histogram_stats.sv @@
// Top level of the RGB/gray 256-bin histogram and statistics block.
//
//   channel   ports                                      handshake
//   request   req_kind req_red/green/blue req_channel     start & !busy
//             req_index
//   response  rsp_value rsp_status                       rsp_valid, one cycle
//
// A count transaction takes a bin RAM read in S_IDLE, then an
// increment/write-back with statistics update in S_EXEC; a read takes
// the same steps. The bin RAM's registered read port sets this: the
// back end finishes one transaction before it pops the next, with a
// 2-deep queue absorbing short bursts. A read's response is registered
// from S_EXEC. After reset a clearing pass zeroes all 256 entries of
// all four bin RAMs; busy is high during it. The receiver cannot stall;
// responses are never held.
`include "rgb_gray_histogram_stats_defines.svh"
module rgb_gray_histogram_stats import rghs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  logic [7:0]          req_red,
   input  logic [7:0]          req_green,
   input  logic [7:0]          req_blue,
   input  logic [1:0]          req_channel,
   input  logic [8:0]          req_index,
   output logic                rsp_valid,
   output logic [SUM_BITS-1:0] rsp_value,
   output logic [1:0]          rsp_status
);

   logic           push;
   logic           pop;
   logic           full;
   logic           clearing;
   queue_head_type head;

   // transaction accepted only when the queue has room and clearing is done
   assign busy = full || clearing;
   assign push = start && !busy;

   rghs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_kind   (req_kind),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .req_channel(req_channel),
      .req_index  (req_index),
      .pop        (pop),
      .full       (full),
      .head       (head)
   );

   rghs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_value (rsp_value),
      .rsp_status(rsp_status)
   );

   `RGHS_ASSERT(a_busy_while_clearing, clearing |-> busy)
   `RGHS_ASSERT(a_status_code_valid, rsp_valid |-> (rsp_status != 2'd3))

endmodule

@@ src/rghs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rghs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/rghs_front.sv @@
// Front end: takes transactions, computes gray, and queues them for the back end.
`include "rgb_gray_histogram_stats_defines.svh"
module rghs_front import rghs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  logic           req_kind,
   input  logic [7:0]     req_red,
   input  logic [7:0]     req_green,
   input  logic [7:0]     req_blue,
   input  logic [1:0]     req_channel,
   input  logic [8:0]     req_index,
   input  logic           pop,
   output logic           full,
   output queue_head_type head
);

   item_type               fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]       cnt_ff, cnt_in;
   logic [12:0]            luma;
   item_type               new_item;

   // gray = (11r + 16g + 5b) / 32, max 8160 fits in 13 bits
   always_comb begin
      luma = 13'(req_red) * 13'd11 + 13'(req_green) * 13'd16 + 13'(req_blue) * 13'd5;
      new_item.kind    = req_kind;
      new_item.red     = req_red;
      new_item.green   = req_green;
      new_item.blue    = req_blue;
      new_item.gray    = luma[12:5];
      new_item.channel = req_channel;
      new_item.index   = req_index;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign full       = (cnt_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.item  = fifo_ff[rd_ptr_ff];

   `RGHS_ASSERT(a_no_push_full, full |-> !push)
   `RGHS_ASSERT(a_no_pop_empty, pop |-> head.valid)

endmodule

@@ src/rghs_back.sv @@
// Back end: bin read-modify-write, running statistics and read responses.
`include "rgb_gray_histogram_stats_defines.svh"
module rghs_back import rghs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  queue_head_type      head,
   output logic                pop,
   output logic                clearing,
   output logic                rsp_valid,
   output logic [SUM_BITS-1:0] rsp_value,
   output logic [1:0]          rsp_status
);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [BIN_AW-1:0]     clr_cnt_ff, clr_cnt_in;
   item_type              item_ff;
   logic                  seen_ff, seen_in;
   logic [COUNT_BITS-1:0] max_ff [4];
   logic [COUNT_BITS-1:0] max_in [4];
   logic [SUM_BITS-1:0]   sum_ff [5];
   logic [SUM_BITS-1:0]   sum_in [5];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   logic                  ram_we    [4];
   logic [BIN_AW-1:0]     ram_waddr [4];
   logic [COUNT_BITS-1:0] ram_wdata [4];
   logic [BIN_AW-1:0]     ram_raddr [4];
   logic [COUNT_BITS-1:0] ram_rdata [4];

   logic [7:0]            lvl  [4];
   logic [7:0]            qlvl [4];
   logic [COUNT_BITS-1:0] inc  [4];
   logic                  grow [4];
   logic                  exec_count;
   logic                  exec_read;
   logic [8:0]            top_idx;
   logic [COUNT_BITS-1:0] bin_sel;

   // channel order: gray, red, green, blue
   always_comb begin
      lvl[0]  = item_ff.gray;
      lvl[1]  = item_ff.red;
      lvl[2]  = item_ff.green;
      lvl[3]  = item_ff.blue;
      qlvl[0] = head.item.gray;
      qlvl[1] = head.item.red;
      qlvl[2] = head.item.green;
      qlvl[3] = head.item.blue;
   end

   genvar gc;
   generate
      for (gc = 0; gc < 4; gc++) begin : g_bins
         rghs_ram #(
            .WIDTH(COUNT_BITS),
            .DEPTH(BINS)
         ) u_ram (
            .clock(clock),
            .we   (ram_we[gc]),
            .waddr(ram_waddr[gc]),
            .wdata(ram_wdata[gc]),
            .raddr(ram_raddr[gc]),
            .rdata(ram_rdata[gc])
         );
      end
   endgenerate

   assign clearing   = (state_ff == S_CLEAR);
   assign pop        = (state_ff == S_IDLE) && head.valid;
   assign exec_count = (state_ff == S_EXEC) && (item_ff.kind == KIND_COUNT);
   assign exec_read  = (state_ff == S_EXEC) && (item_ff.kind == KIND_READ);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         inc[c]       = ram_rdata[c] + 1'b1;
         grow[c]      = exec_count && (ram_rdata[c] != COUNT_FULL);
         ram_we[c]    = clearing || grow[c];
         ram_waddr[c] = clearing ? clr_cnt_ff : lvl[c];
         ram_wdata[c] = clearing ? '0 : inc[c];
         ram_raddr[c] = (head.item.kind == KIND_READ) ? head.item.index[BIN_AW-1:0]
                                                      : qlvl[c];
         max_in[c]    = (grow[c] && (inc[c] > max_ff[c])) ? inc[c] : max_ff[c];
      end
   end

   // dark and light gray sums, then the colour sums
   always_comb begin
      sum_in[0] = sum_ff[0];
      sum_in[4] = sum_ff[4];
      if (grow[0]) begin
         if (item_ff.gray <= MID_LEVEL) begin
            sum_in[0] = sat_add(sum_ff[0], MID_LEVEL - item_ff.gray);
         end else begin
            sum_in[4] = sat_add(sum_ff[4], item_ff.gray - MID_LEVEL);
         end
      end
      for (int c = 1; c < 4; c++) begin
         sum_in[c] = grow[c] ? sat_add(sum_ff[c], lvl[c]) : sum_ff[c];
      end
   end

   always_comb begin
      top_idx       = (item_ff.channel == CH_GRAY) ? IDX_LIGHT : IDX_SUM;
      bin_sel       = ram_rdata[item_ff.channel];
      rsp_valid_in  = exec_read;
      rsp_value_in  = '0;
      rsp_status_in = ST_OK;
      if (item_ff.index > top_idx) begin
         rsp_status_in = ST_RANGE;
      end else if (!seen_ff) begin
         rsp_status_in = ST_EMPTY;
      end else if (item_ff.index < IDX_MAX) begin
         rsp_value_in = SUM_BITS'(bin_sel);
      end else if (item_ff.index == IDX_MAX) begin
         rsp_value_in = SUM_BITS'(max_ff[item_ff.channel]);
      end else if (item_ff.index == IDX_SUM) begin
         rsp_value_in = sum_ff[item_ff.channel];
      end else begin
         rsp_value_in = sum_ff[4];
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      seen_in    = seen_ff || exec_count;
      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == BIN_AW'(BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < 4; c++) begin
            max_ff[c] <= '0;
         end
         for (int s = 0; s < 5; s++) begin
            sum_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < 4; c++) begin
            max_ff[c] <= max_in[c];
         end
         for (int s = 0; s < 5; s++) begin
            sum_ff[s] <= sum_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head.item;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   `RGHS_ASSERT(a_rsp_only_after_read,
      rsp_valid_ff |-> ($past(state_ff) == S_EXEC) && ($past(item_ff.kind) == KIND_READ))
   `RGHS_ASSERT(a_exec_one_cycle, (state_ff == S_EXEC) |=> (state_ff == S_IDLE))
   `RGHS_ASSERT(a_no_write_on_read, exec_read |-> !ram_we[0] && !ram_we[1])
   `RGHS_ASSERT_ALWAYS(a_reset_enters_clear, reset |=> (state_ff == S_CLEAR))

endmodule

@@ dv/rgb_gray_histogram_stats_test.sv @@
// Self-checking testbench for the RGB/gray histogram and statistics block.
`timescale 1ns / 1ps
module rgb_gray_histogram_stats_test;
   import rghs_pkg::*;

   // Read channels other than gray; gray comes from the package.
   localparam logic [1:0] CH_RED   = 2'd1;
   localparam logic [1:0] CH_GREEN = 2'd2;
   localparam logic [1:0] CH_BLUE  = 2'd3;

   // Slot of the gray light sum; slots 0..3 hold gray dark, red, green, blue.
   localparam int SLOT_LIGHT = 4;

   // Watchdog: cycles with neither a request nor a response transaction.
   // Worst honest gap is the clear pass after reset plus a long random
   // sender gap, so this leaves plenty of margin.
   localparam int STALL_LIMIT  = 2000;
   // Settling time after the last expected response, long enough for a
   // read to pass through a full 2-deep queue and the back end.
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [SUM_BITS-1:0] value;
      logic [1:0]          status;
   } read_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_kind    = KIND_COUNT;
   logic [7:0]          req_red     = '0;
   logic [7:0]          req_green   = '0;
   logic [7:0]          req_blue    = '0;
   logic [1:0]          req_channel = '0;
   logic [8:0]          req_index   = '0;
   logic                rsp_valid;
   logic [SUM_BITS-1:0] rsp_value;
   logic [1:0]          rsp_status;

   // Shadow copy of the histogram state, updated at each accepted count transaction.
   logic [COUNT_BITS-1:0] bin_count [4][BINS];
   logic [COUNT_BITS-1:0] chan_peak [4];
   logic [SUM_BITS-1:0]   level_sum [5];
   logic                  pixel_seen;
   logic [7:0]            last_levels [4];   // bins hit by the latest pixel

   read_result_type expected_reads [$];
   int              mismatch_count = 0;
   int              quiet_cycles   = 0;
   int              idle_pct       = 0;

   always #10 clock = ~clock;

   rgb_gray_histogram_stats uut (
      .clock,
      .reset,
      .start,
      .busy,
      .req_kind,
      .req_red,
      .req_green,
      .req_blue,
      .req_channel,
      .req_index,
      .rsp_valid,
      .rsp_value,
      .rsp_status
   );

   // Bump the four bins one pixel selects. A full bin adds nothing to the
   // sums, so every sum stays consistent with the stored bins.
   function automatic void histogram_count_pixel(input logic [7:0] r, g, b);
      int unsigned         gray_level;
      logic [7:0]          lvl;
      logic [7:0]          amount;
      int                  slot;
      logic [SUM_BITS:0]   total;
      gray_level = (32'(r) * 11 + 32'(g) * 16 + 32'(b) * 5) >> 5;
      last_levels[CH_GRAY]  = gray_level[7:0];
      last_levels[CH_RED]   = r;
      last_levels[CH_GREEN] = g;
      last_levels[CH_BLUE]  = b;
      pixel_seen = 1'b1;
      for (int c = 0; c < 4; c++) begin
         lvl = last_levels[c];
         if (bin_count[c][lvl] != COUNT_FULL) begin
            bin_count[c][lvl] = bin_count[c][lvl] + 1'b1;
            if (bin_count[c][lvl] > chan_peak[c])
               chan_peak[c] = bin_count[c][lvl];
            // gray splits into a dark sum (at or below mid) and a light sum
            if (c != CH_GRAY) begin
               slot   = c;
               amount = lvl;
            end else if (lvl <= MID_LEVEL) begin
               slot   = int'(CH_GRAY);
               amount = MID_LEVEL - lvl;
            end else begin
               slot   = SLOT_LIGHT;
               amount = lvl - MID_LEVEL;
            end
            total = {1'b0, level_sum[slot]} + (SUM_BITS + 1)'(amount);
            level_sum[slot] = total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];
         end
      end
   endfunction

   // Expected response to a read; range error wins over the empty case.
   function automatic read_result_type histogram_lookup(input logic [1:0] ch,
                                                        input logic [8:0] idx);
      read_result_type res;
      logic [8:0]      top;
      res = '0;
      top = (ch == CH_GRAY) ? IDX_LIGHT : IDX_SUM;
      if (idx > top) begin
         res.status = ST_RANGE;
      end else if (!pixel_seen) begin
         res.status = ST_EMPTY;
      end else begin
         res.status = ST_OK;
         if (idx < IDX_MAX)
            res.value = SUM_BITS'(bin_count[ch][idx[7:0]]);
         else if (idx == IDX_MAX)
            res.value = SUM_BITS'(chan_peak[ch]);
         else if (idx == IDX_SUM)
            res.value = level_sum[ch];
         else
            res.value = level_sum[SLOT_LIGHT];
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input logic [SUM_BITS-1:0] want,
                                input logic [SUM_BITS-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, want, got);
   endtask

   // Present one transaction and hold it until the block takes it. With no
   // idle draw, start stays high so the next call overwrites the fields in
   // the same step: back-to-back transactions with a single assignment each.
   task automatic send_request(input logic kind, input logic [7:0] r, g, b,
                               input logic [1:0] ch, input logic [8:0] idx);
      req_kind    <= kind;
      req_red     <= r;
      req_green   <= g;
      req_blue    <= b;
      req_channel <= ch;
      req_index   <= idx;
      start       <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (kind == KIND_COUNT)
         histogram_count_pixel(r, g, b);
      else
         expected_reads.push_back(histogram_lookup(ch, idx));
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Sender holds off until every outstanding read has answered.
   task automatic wait_for_responses();
      start <= 1'b0;
      while (expected_reads.size() != 0)
         @(posedge clock);
   endtask

   // Reads before any pixel: empty status when in range, range error beyond.
   task automatic test_empty_reads();
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GRAY,  9'd0);
      send_request(KIND_READ, 8'hFF, 8'hFF, 8'hFF, CH_BLUE,  IDX_SUM);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GRAY,  IDX_LIGHT);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_RED,   IDX_LIGHT);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GRAY,  IDX_LIGHT + 9'd1);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GREEN, 9'h1FF);
   endtask

   // Corner pixels: black, white, pure primaries, gray just at and just
   // above the mid level. Channel and index fields are don't-care here.
   task automatic test_pixel_extremes();
      send_request(KIND_COUNT, 8'h00, 8'h00, 8'h00, CH_BLUE, 9'h1FF);
      send_request(KIND_COUNT, 8'hFF, 8'hFF, 8'hFF, CH_GRAY, 9'd0);
      send_request(KIND_COUNT, 8'hFF, 8'h00, 8'h00, CH_RED,  9'd300);
      send_request(KIND_COUNT, 8'h00, 8'hFF, 8'h00, CH_GRAY, IDX_MAX);
      send_request(KIND_COUNT, 8'h00, 8'h00, 8'hFF, CH_GREEN, 9'd5);
      send_request(KIND_COUNT, 8'h00, 8'hFF, 8'h04, CH_BLUE, IDX_LIGHT);
      send_request(KIND_COUNT, 8'h00, 8'h00, 8'h00, CH_GRAY, 9'd0);
   endtask

   // Read every kind of index back after the corner pixels.
   task automatic test_stat_readback();
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GRAY,  9'd0);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GRAY,  9'd127);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GRAY,  9'd128);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_RED,   9'd255);
      send_request(KIND_READ, 8'hFF, 8'hFF, 8'hFF, CH_BLUE,  9'd0);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GRAY,  IDX_MAX);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GRAY,  IDX_SUM);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GRAY,  IDX_LIGHT);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_RED,   IDX_SUM);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_GREEN, IDX_MAX);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_BLUE,  IDX_SUM);
      send_request(KIND_READ, 8'h00, 8'h00, 8'h00, CH_RED,   IDX_LIGHT);
   endtask

   // Mixed traffic: pixels drawn partly from a small palette so bins and
   // peaks climb, reads aimed mostly at bins just hit and at the statistics.
   task automatic test_random_traffic(input int count, input int idle);
      logic [7:0] palette [8][3];
      logic [7:0] px [3];
      logic [1:0] ch;
      logic [8:0] idx;
      int         roll;
      idle_pct = idle;
      for (int p = 0; p < 8; p++)
         for (int k = 0; k < 3; k++)
            palette[p][k] = 8'($urandom_range(255));
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 60) begin
            if ($urandom_range(1) == 1)
               px = palette[$urandom_range(7)];
            else
               for (int k = 0; k < 3; k++)
                  px[k] = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                                   : 8'($urandom_range(255));
            send_request(KIND_COUNT, px[0], px[1], px[2], 2'($urandom()), 9'($urandom()));
         end else begin
            ch   = 2'($urandom());
            roll = $urandom_range(99);
            if (roll < 40)
               idx = {1'b0, last_levels[ch]};
            else if (roll < 60)
               idx = 9'($urandom_range(255));
            else if (roll < 90)
               idx = 9'($urandom_range(IDX_LIGHT, IDX_MAX));
            else
               idx = 9'($urandom());
            send_request(KIND_READ, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                         ch, idx);
         end
      end
   endtask

   // Every response transaction must match the oldest outstanding read.
   always @(posedge clock) begin : check_responses
      read_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_reads.size() == 0) begin
            flag_mismatch("response with no read outstanding, rsp_value", '0, rsp_value);
         end else begin
            want = expected_reads.pop_front();
            if (rsp_value !== want.value)
               flag_mismatch("rsp_value", want.value, rsp_value);
            if (rsp_status !== want.status)
               flag_mismatch("rsp_status", SUM_BITS'(want.status), SUM_BITS'(rsp_status));
         end
      end
   end

   // Watchdog on progress; reset and the clear pass fall within the limit.
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < BINS; i++)
            bin_count[c][i] = '0;
         chan_peak[c]   = '0;
         last_levels[c] = '0;
      end
      for (int s = 0; s < 5; s++)
         level_sum[s] = '0;
      pixel_seen = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part, back to back, then a full drain
      idle_pct = 0;
      test_empty_reads();
      test_pixel_extremes();
      test_stat_readback();
      wait_for_responses();

      // random part: light sender gaps, heavy gaps, then none
      test_random_traffic(220, 18);
      test_random_traffic(220, 73);
      test_random_traffic(210, 0);

      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_reads.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/rghs_pkg.sv
src/rghs_ram.sv
src/rghs_front.sv
src/rghs_back.sv
src/rgb_gray_histogram_stats.sv
dv/rgb_gray_histogram_stats_test.sv
